// ----- design/tsp_pkg.sv -----
// ----------------------------------------------------------------------------
// tsp_pkg
// Types, register indexes and fixed constants shared by the tilt to servo
// pulse unit and its CORDIC pipeline.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // Width of the CORDIC angle accumulator, in 1/256 of 0.01 degree.
  localparam int ANGLE_W = 24;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  // Number of entries in the arctangent table.
  localparam int ATAN_LEN = 24;

  // Configuration register indexes and port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_PULSE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE       = 3'd4;

  // Register reset values.
  localparam logic [13:0] DEAD_ZONE_RST       = 14'd500;
  localparam logic [13:0] ALERT_THRESHOLD_RST = 14'd4500;
  localparam logic [11:0] STOP_PULSE_RST      = 12'd1500;
  localparam logic [11:0] MIN_PULSE_RST       = 12'd500;
  localparam logic [11:0] MAX_PULSE_RST       = 12'd2500;

  // Inverse CORDIC gain in Q16.
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  // Pitch limits and mapping span in 0.01 degree.
  localparam logic signed [15:0] PITCH_MAX  = 16'sd9000;
  localparam logic signed [15:0] PITCH_MIN  = -16'sd9000;
  localparam logic [14:0]        PITCH_SPAN = 15'd18000;

  // Division by 18000 is a shift by four and a multiply by ceil(2^32 / 1125).
  // The error term of the reciprocal is small enough that the floor is exact
  // for every dividend below 2^23.
  localparam logic [21:0] RECIP_1125 = 22'd3817749;

  // One input request.
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } tsp_in_t;

  // One result.
  typedef struct packed {
    logic signed [14:0] pitch_angle;
    logic [11:0]        pulse_width;
    logic               alert;
  } tsp_out_t;

  // Arctangent of 2^-i, rounded to 1/256 of 0.01 degree.
  function automatic angle_t atan_entry(input int unsigned idx);
    angle_t val;
    case (idx)
      0:       val = 24'sd1152000;
      1:       val = 24'sd680065;
      2:       val = 24'sd359328;
      3:       val = 24'sd182400;
      4:       val = 24'sd91554;
      5:       val = 24'sd45822;
      6:       val = 24'sd22916;
      7:       val = 24'sd11459;
      8:       val = 24'sd5730;
      9:       val = 24'sd2865;
      10:      val = 24'sd1432;
      11:      val = 24'sd716;
      12:      val = 24'sd358;
      13:      val = 24'sd179;
      14:      val = 24'sd90;
      15:      val = 24'sd45;
      16:      val = 24'sd22;
      17:      val = 24'sd11;
      18:      val = 24'sd6;
      19:      val = 24'sd3;
      20:      val = 24'sd1;
      21:      val = 24'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- design/tsp_cordic_vec.sv -----
// ----------------------------------------------------------------------------
// tsp_cordic_vec
// Unrolled vectoring CORDIC, one register stage per iteration. Drives b
// toward zero and returns the gained magnitude and the accumulated angle.
// ----------------------------------------------------------------------------
module tsp_cordic_vec #(
  parameter int W      = 27,
  parameter int TW     = 1,
  parameter int STAGES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [W-1:0]   in_a_i,
  input  logic signed [W-1:0]   in_b_i,
  input  logic [TW-1:0]         in_tag_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [W-1:0]   out_a_o,
  output tsp_pkg::angle_t       out_z_o,
  output logic [TW-1:0]         out_tag_o
);
  import tsp_pkg::*;

  logic                v_q   [STAGES];
  logic signed [W-1:0] a_q   [STAGES];
  logic signed [W-1:0] b_q   [STAGES];
  angle_t              z_q   [STAGES];
  logic [TW-1:0]       tag_q [STAGES];
  logic [STAGES:0]     en;

  // A stage loads when it is empty or the stage after it moves on.
  assign en[STAGES] = !out_stall_i;
  assign in_stall_o = !en[0];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [W-1:0] a_in;
    logic signed [W-1:0] b_in;
    angle_t              z_in;
    logic [TW-1:0]       t_in;
    logic                v_in;
    logic signed [W-1:0] da;
    logic signed [W-1:0] db;

    if (i == 0) begin : g_first
      assign a_in = in_a_i;
      assign b_in = in_b_i;
      assign z_in = '0;
      assign t_in = in_tag_i;
      assign v_in = in_valid_i;
    end else begin : g_next
      assign a_in = a_q[i-1];
      assign b_in = b_q[i-1];
      assign z_in = z_q[i-1];
      assign t_in = tag_q[i-1];
      assign v_in = v_q[i-1];
    end

    // Floor shifts of both coordinates for this iteration.
    assign da = b_in >>> i;
    assign db = a_in >>> i;

    assign en[i] = !v_q[i] || en[i+1];

    // Stage valid bit.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en[i]) begin
        v_q[i] <= v_in;
      end
    end

    // Rotate toward the positive a axis.
    always_ff @(posedge clk_i) begin
      if (en[i]) begin
        if (!b_in[W-1]) begin
          a_q[i] <= a_in + da;
          b_q[i] <= b_in - db;
          z_q[i] <= z_in + atan_entry(i);
        end else begin
          a_q[i] <= a_in - da;
          b_q[i] <= b_in + db;
          z_q[i] <= z_in - atan_entry(i);
        end
        tag_q[i] <= t_in;
      end
    end
  end

  assign out_valid_o = v_q[STAGES-1];
  assign out_a_o     = a_q[STAGES-1];
  assign out_z_o     = z_q[STAGES-1];
  assign out_tag_o   = tag_q[STAGES-1];

endmodule

// ----- design/tilt_to_servo_pulse_unit.sv -----
// ----------------------------------------------------------------------------
// tilt_to_servo_pulse_unit
// Accelerometer pitch by two CORDIC passes, mapped to a servo pulse width.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one raw x, y, z sample per request; the output
// channel returns pitch in 0.01 degree, the servo pulse width in microseconds
// and an alert flag. Both use valid and stall; a request moves on an edge
// with valid high and stall low.
// The pipeline holds an input register, the magnitude CORDIC, the gain
// multiply, the angle CORDIC, a rounding stage and four stages for the
// pulse mapping. The input takes one request per cycle unless every stage is
// full and the output stalls. Every stage has its own valid bit and
// loads whenever it is empty or its successor moves, so bubbles close up and
// the input keeps accepting while a result waits at the output.
// When the receiver stalls, results pile up stage by stage; in_stall_o rises
// only when every stage holds a request.
// Reset empties the pipeline and restores the five configuration registers.
// Write configuration only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tilt_to_servo_pulse_unit #(
  parameter int SAMPLE_BITS   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tsp_pkg::tsp_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tsp_pkg::tsp_out_t                  out_data_o,
  input  logic                               cfg_we_i,
  input  logic [tsp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tsp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import tsp_pkg::*;

  // Datapath width: samples carry 8 fraction bits and the CORDIC gain.
  localparam int W  = SAMPLE_BITS + 11;
  localparam int PW = W + 17;
  localparam int RAW_W = 24;

  // Configuration registers.
  logic [13:0] dead_zone_q;
  logic [13:0] alert_threshold_q;
  logic [11:0] stop_pulse_q;
  logic [11:0] min_pulse_q;
  logic [11:0] max_pulse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q       <= DEAD_ZONE_RST;
      alert_threshold_q <= ALERT_THRESHOLD_RST;
      stop_pulse_q      <= STOP_PULSE_RST;
      min_pulse_q       <= MIN_PULSE_RST;
      max_pulse_q       <= MAX_PULSE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEAD_ZONE:       dead_zone_q       <= cfg_data_i;
        CFG_ALERT_THRESHOLD: alert_threshold_q <= cfg_data_i;
        CFG_STOP_PULSE:      stop_pulse_q      <= cfg_data_i[11:0];
        CFG_MIN_PULSE:       min_pulse_q       <= cfg_data_i[11:0];
        CFG_MAX_PULSE:       max_pulse_q       <= cfg_data_i[11:0];
        default:             ;
      endcase
    end
  end

  // Stage valid bits and load enables.
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en0, en1, en2, en3, en4, en5, en6;
  logic c1_in_stall, c1_out_valid;
  logic c2_in_stall, c2_out_valid;

  assign en6 = !v6_q || !out_stall_i;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || !c2_in_stall;
  assign en0 = !v0_q || !c1_in_stall;
  assign in_stall_o = !en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= c1_out_valid;
      if (en2) v2_q <= c2_out_valid;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // Input stage: sign-extend from SAMPLE_BITS, fold y and z into the first
  // quadrant and scale to 8 fraction bits.
  logic [RAW_W-1:0]    raw_x, raw_y, raw_z;
  logic signed [W-1:0] sx, sy, sz;
  logic signed [W-1:0] ay, az;
  logic signed [W-1:0] a0_q, b0_q, nx0_q;
  logic                zero0_q;

  assign raw_x = {8'b0, in_data_i.accel_x};
  assign raw_y = {8'b0, in_data_i.accel_y};
  assign raw_z = {8'b0, in_data_i.accel_z};
  assign sx = W'($signed(raw_x[SAMPLE_BITS-1:0]));
  assign sy = W'($signed(raw_y[SAMPLE_BITS-1:0]));
  assign sz = W'($signed(raw_z[SAMPLE_BITS-1:0]));
  assign ay = sy[W-1] ? -sy : sy;
  assign az = sz[W-1] ? -sz : sz;

  always_ff @(posedge clk_i) begin
    if (en0) begin
      a0_q    <= az <<< 8;
      b0_q    <= ay <<< 8;
      nx0_q   <= (-sx) <<< 8;
      zero0_q <= (sx == '0) && (sy == '0) && (sz == '0);
    end
  end

  // Magnitude of (|z|, |y|).
  logic signed [W-1:0] c1_a;
  logic [W:0]          c1_tag;

  tsp_cordic_vec #(
    .W      (W),
    .TW     (W + 1),
    .STAGES (CORDIC_STAGES)
  ) u_cordic_mag (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v0_q),
    .in_stall_o  (c1_in_stall),
    .in_a_i      (a0_q),
    .in_b_i      (b0_q),
    .in_tag_i    ({zero0_q, nx0_q}),
    .out_valid_o (c1_out_valid),
    .out_stall_i (!en1),
    .out_a_o     (c1_a),
    .out_z_o     (),
    .out_tag_o   (c1_tag)
  );

  // Gain correction. The magnitude is never negative, so the product is
  // taken unsigned and the floor shift by 16 is a part-select.
  logic [PW-1:0]       gp_q;
  logic signed [W-1:0] nx1_q;
  logic                zero1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      gp_q    <= PW'(unsigned'(c1_a)) * PW'(INV_GAIN_Q16);
      nx1_q   <= $signed(c1_tag[W-1:0]);
      zero1_q <= c1_tag[W];
    end
  end

  // Angle of (r, -x).
  angle_t c2_z;
  logic   c2_zero;

  tsp_cordic_vec #(
    .W      (W),
    .TW     (1),
    .STAGES (CORDIC_STAGES)
  ) u_cordic_ang (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_stall_o  (c2_in_stall),
    .in_a_i      ($signed(gp_q[W+15:16])),
    .in_b_i      (nx1_q),
    .in_tag_i    (zero1_q),
    .out_valid_o (c2_out_valid),
    .out_stall_i (!en2),
    .out_a_o     (),
    .out_z_o     (c2_z),
    .out_tag_o   (c2_zero)
  );

  // Round half up to 0.01 degree and clamp to plus or minus 90 degrees; an all-zero sample gives 0.
  logic signed [ANGLE_W:0] zsum;
  logic signed [15:0]      zr;
  logic signed [15:0]      pitch_c;
  logic signed [14:0]      pitch2_q;
  logic [13:0]             apitch2_q;

  assign zsum = {c2_z[ANGLE_W-1], c2_z} + 25'sd128;
  assign zr   = zsum[23:8];

  always_comb begin
    if (c2_zero) begin
      pitch_c = '0;
    end else if (zr > PITCH_MAX) begin
      pitch_c = PITCH_MAX;
    end else if (zr < PITCH_MIN) begin
      pitch_c = PITCH_MIN;
    end else begin
      pitch_c = zr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      pitch2_q  <= pitch_c[14:0];
      apitch2_q <= pitch_c[15] ? 14'(-pitch_c) : pitch_c[13:0];
    end
  end

  // Linear map: the numerator is max*(18000-p) + min*p with p = pitch+9000,
  // so both terms are non-negative.
  logic [14:0]        pp;
  logic [26:0]        pm3_q, pn3_q;
  logic signed [14:0] pitch3_q;
  logic [13:0]        apitch3_q;

  assign pp = 15'($signed({pitch2_q[14], pitch2_q}) + 16'sd9000);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      pm3_q     <= 27'(max_pulse_q) * 27'(PITCH_SPAN - pp);
      pn3_q     <= 27'(min_pulse_q) * 27'(pp);
      pitch3_q  <= pitch2_q;
      apitch3_q <= apitch2_q;
    end
  end

  // Sum and the divide-by-16 part of the division by 18000.
  logic [26:0]        num;
  logic [22:0]        q1_4_q;
  logic signed [14:0] pitch4_q;
  logic [13:0]        apitch4_q;

  assign num = pm3_q + pn3_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      q1_4_q    <= num[26:4];
      pitch4_q  <= pitch3_q;
      apitch4_q <= apitch3_q;
    end
  end

  // Divide by 1125 through the reciprocal.
  logic [44:0]        qprod;
  logic [11:0]        map5_q;
  logic signed [14:0] pitch5_q;
  logic [13:0]        apitch5_q;

  assign qprod = 45'(q1_4_q) * 45'(RECIP_1125);

  always_ff @(posedge clk_i) begin
    if (en5) begin
      map5_q    <= qprod[43:32];
      pitch5_q  <= pitch4_q;
      apitch5_q <= apitch4_q;
    end
  end

  // Dead zone, clamps and alert into the output register. The lower clamp
  // goes first, so the upper clamp wins when the limits are inverted.
  logic [11:0] lo_c;
  logic [11:0] pulse_c;
  tsp_out_t    out_q;

  assign lo_c = (map5_q < min_pulse_q) ? min_pulse_q : map5_q;

  always_comb begin
    if ({1'b0, apitch5_q} < {1'b0, dead_zone_q}) begin
      pulse_c = stop_pulse_q;
    end else if (lo_c > max_pulse_q) begin
      pulse_c = max_pulse_q;
    end else begin
      pulse_c = lo_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      out_q.pitch_angle <= pitch5_q;
      out_q.pulse_width <= pulse_c;
      out_q.alert       <= apitch5_q > alert_threshold_q;
    end
  end

  assign out_valid_o = v6_q;
  assign out_data_o  = out_q;

  // The input only stalls when the whole pipeline is full and blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v0_q && out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline had room");

  // A delivered pitch never leaves plus or minus 90 degrees.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (($signed(out_data_o.pitch_angle) <= 15'sd9000) &&
                     ($signed(out_data_o.pitch_angle) >= -15'sd9000)))
    else $error("pitch out of range");

  // Outside the dead zone the upper clamp always holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.pulse_width == stop_pulse_q) ||
                     (out_data_o.pulse_width <= max_pulse_q)))
    else $error("pulse width above the upper clamp");

endmodule

// ----- tb/sv/tilt_to_servo_pulse_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_to_servo_pulse_unit_tb
// Self-checking bench for the accelerometer pitch to servo pulse unit.
// Each accepted sample is run through a bit-exact software copy of the two
// CORDIC passes and the pulse mapping, and every result leaving the unit is
// compared field by field with the oldest prediction. Corner samples, register
// corners, random traffic under three idle mixes and a long output hold-off
// are applied in turn.
// ----------------------------------------------------------------------------
module tilt_to_servo_pulse_unit_tb;
  import tsp_pkg::*;

  localparam int SAMPLE_BITS   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int LATENCY       = 2 * CORDIC_STAGES + 7;
  localparam int QUIET_LIMIT   = 4000;
  localparam int ANGLE_STEPS   = 24;
  localparam longint GAIN_RECIP_Q16 = 39797;
  localparam int CORNER_COUNT  = 21;

  // Arctangent of 2^-i in 1/256 of 0.01 degree.
  localparam longint ATAN_LUT [ANGLE_STEPS] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45,
    22, 11, 6, 3, 1, 1, 0, 0
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  tsp_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  tsp_out_t              out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Register shadow used by the predictor, starting at the reset values.
  logic [13:0] dead_zone_set  = 14'd500;
  logic [13:0] alert_level    = 14'd4500;
  logic [11:0] stop_width     = 12'd1500;
  logic [11:0] min_width      = 12'd500;
  logic [11:0] max_width      = 12'd2500;

  tsp_out_t servo_expect_q [$];
  tsp_out_t servo_exp;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int recv_hold_left  = 0;
  int fail_count      = 0;
  int mismatch_count  = 0;

  tilt_to_servo_pulse_unit #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sign-extend a raw sample from its low SAMPLE_BITS bits.
  function automatic longint widen(logic [15:0] raw);
    logic signed [63:0] t;
    t = 64'(raw) << (64 - SAMPLE_BITS);
    return t >>> (64 - SAMPLE_BITS);
  endfunction

  // Vectoring CORDIC with floor shifts; returns the gained magnitude.
  function automatic longint cordic_vector(input longint a, input longint b,
                                           output longint ang);
    longint da;
    longint db;
    ang = 0;
    for (int i = 0; i < CORDIC_STAGES && i < ANGLE_STEPS; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a   = a + da;
        b   = b - db;
        ang = ang + ATAN_LUT[i];
      end else begin
        a   = a - da;
        b   = b + db;
        ang = ang - ATAN_LUT[i];
      end
    end
    return a;
  endfunction

  // Expected pitch, pulse width and alert for one sample.
  function automatic tsp_out_t predict_servo(tsp_in_t s);
    longint ax, ay, az, mag, ang, pitch, apitch, num, pulse;
    tsp_out_t r;
    ax = widen(s.accel_x);
    ay = widen(s.accel_y);
    az = widen(s.accel_z);
    if (ay < 0) ay = -ay;
    if (az < 0) az = -az;
    if (ax == 0 && ay == 0 && az == 0) begin
      pitch = 0;
    end else begin
      mag = cordic_vector(az * 256, ay * 256, ang);
      mag = (mag * GAIN_RECIP_Q16) >>> 16;
      void'(cordic_vector(mag, -ax * 256, ang));
      pitch = (ang + 128) >>> 8;
      if (pitch > 9000) pitch = 9000;
      if (pitch < -9000) pitch = -9000;
    end
    apitch = (pitch < 0) ? -pitch : pitch;
    if (apitch < longint'(dead_zone_set)) begin
      pulse = longint'(stop_width);
    end else begin
      // Lower clamp first, so with inverted limits the upper one wins.
      num = longint'(max_width) * 18000
          + (pitch + 9000) * (longint'(min_width) - longint'(max_width));
      pulse = num / 18000;
      if (pulse < longint'(min_width)) pulse = longint'(min_width);
      if (pulse > longint'(max_width)) pulse = longint'(max_width);
    end
    r.pitch_angle = 15'(pitch);
    r.pulse_width = 12'(pulse);
    r.alert       = (apitch > longint'(alert_level));
    return r;
  endfunction

  function automatic tsp_in_t pack_sample(int x, int y, int z);
    tsp_in_t s;
    s.accel_x = 16'(x);
    s.accel_y = 16'(y);
    s.accel_z = 16'(z);
    return s;
  endfunction

  // Hand-picked samples: axis extremes, the all-zero tilt, +-45 degrees and
  // small tilts that land around the stop zone.
  function automatic tsp_in_t corner_sample(int k);
    case (k)
      0:       return pack_sample(0, 0, 0);
      1:       return pack_sample(32767, 0, 0);
      2:       return pack_sample(-32768, 0, 0);
      3:       return pack_sample(0, 32767, 0);
      4:       return pack_sample(0, -32768, 0);
      5:       return pack_sample(0, 0, 32767);
      6:       return pack_sample(0, 0, -32768);
      7:       return pack_sample(32767, 32767, 32767);
      8:       return pack_sample(-32768, -32768, -32768);
      9:       return pack_sample(1, 0, 0);
      10:      return pack_sample(-1, 0, 0);
      11:      return pack_sample(0, 1, 0);
      12:      return pack_sample(0, -1, -1);
      13:      return pack_sample(-16384, 0, 16384);
      14:      return pack_sample(16384, 0, -16384);
      15:      return pack_sample(200, 0, 16384);
      16:      return pack_sample(-200, 0, -16384);
      17:      return pack_sample(-23170, 16384, 16384);
      18:      return pack_sample(32767, -32768, 1);
      19:      return pack_sample(-12000, 5000, -14000);
      default: return pack_sample(-32768, 32767, -32768);
    endcase
  endfunction

  // Gravity-sized vectors, full-range noise, tiny values, full-scale x and samples with x zero.
  function automatic tsp_in_t random_sample();
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2:
        return pack_sample($urandom, $urandom, $urandom);
      3, 4, 5:
        return pack_sample(int'($urandom_range(34000)) - 17000,
                           int'($urandom_range(34000)) - 17000,
                           int'($urandom_range(34000)) - 17000);
      6:
        return pack_sample(int'($urandom_range(6)) - 3, int'($urandom_range(6)) - 3,
                           int'($urandom_range(6)) - 3);
      7:
        return pack_sample(int'($urandom_range(600)) - 300, int'($urandom_range(2000)) - 1000,
                           ($urandom_range(1) != 0) ? 16384 : -16384);
      8:
        return pack_sample(($urandom_range(1) != 0) ? 32767 : -32768,
                           ($urandom_range(1) != 0) ? 0 : int'($urandom),
                           ($urandom_range(1) != 0) ? 0 : int'($urandom));
      default:
        return pack_sample(0, $urandom, $urandom);
    endcase
  endfunction

  // Offer one request, hold it until accepted, then record its prediction.
  task automatic send_request(tsp_in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    servo_expect_q.push_back(predict_servo(s));
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (servo_expect_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // One register write; the caller lowers the write enable afterwards.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      CFG_DEAD_ZONE:       dead_zone_set = val;
      CFG_ALERT_THRESHOLD: alert_level   = val;
      CFG_STOP_PULSE:      stop_width    = val[11:0];
      CFG_MIN_PULSE:       min_width     = val[11:0];
      CFG_MAX_PULSE:       max_width     = val[11:0];
      default: ;
    endcase
  endtask

  task automatic configure(int dz, int thr, int stop, int lo, int hi);
    wait_idle();
    write_reg(CFG_DEAD_ZONE, 14'(dz));
    write_reg(CFG_ALERT_THRESHOLD, 14'(thr));
    write_reg(CFG_STOP_PULSE, 14'(stop));
    write_reg(CFG_MIN_PULSE, 14'(lo));
    write_reg(CFG_MAX_PULSE, 14'(hi));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_corners(int count);
    for (int k = 0; k < count; k++) send_request(corner_sample(k));
  endtask

  // All corner samples with the reset configuration.
  task automatic test_directed_corners();
    send_corners(CORNER_COUNT);
  endtask

  // Register extremes, inverted clamps, ignored indexes and width masking.
  task automatic test_register_corners();
    configure(0, 0, 0, 0, 4095);
    send_corners(10);
    configure(9000, 9000, 4095, 4095, 0);
    send_corners(10);
    configure(4000, 2000, 1000, 2600, 1200);
    send_corners(6);
    wait_idle();
    // Writes past the last register must leave every register unchanged.
    for (int idx = int'(CFG_MAX_PULSE) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), '1);
    end
    // The top bits of a 12-bit register are dropped.
    write_reg(CFG_STOP_PULSE, 14'h3ABC);
    write_reg(CFG_MAX_PULSE, 14'h1FA0);
    cfg_we_i <= 1'b0;
    send_corners(CORNER_COUNT);
  endtask

  // Random samples under one random configuration.
  task automatic test_random_traffic(int count);
    configure($urandom_range(9000), $urandom_range(9000), $urandom_range(4095),
              $urandom_range(4095), $urandom_range(4095));
    for (int n = 0; n < count; n++) send_request(random_sample());
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall
  // the input while the sender keeps pushing.
  task automatic test_backpressure();
    wait_idle();
    send_idle_pct  = 0;
    recv_hold_left = 160;
    for (int n = 0; n < 80; n++) send_request(random_sample());
    wait_idle();
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (servo_expect_q.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: pitch %0d pulse %0d alert %0d",
                   out_data_o.pitch_angle, out_data_o.pulse_width, out_data_o.alert);
        end
      end else begin
        servo_exp = servo_expect_q.pop_front();
        if (out_data_o.pitch_angle !== servo_exp.pitch_angle ||
            out_data_o.pulse_width !== servo_exp.pulse_width ||
            out_data_o.alert !== servo_exp.alert) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: pitch %0d/%0d pulse %0d/%0d alert %0d/%0d (exp/got)",
                     servo_exp.pitch_angle, out_data_o.pitch_angle,
                     servo_exp.pulse_width, out_data_o.pulse_width,
                     servo_exp.alert, out_data_o.alert);
          end
        end
      end
    end
    if (recv_hold_left > 0) begin
      out_stall_i <= 1'b1;
      recv_hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("** tilt_to_servo_pulse_unit: FAILED **");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 32;
    recv_stall_pct = 82;
    test_directed_corners();
    test_register_corners();
    test_random_traffic(90);
    test_random_traffic(90);

    send_idle_pct  = 82;
    recv_stall_pct = 32;
    test_random_traffic(90);
    test_random_traffic(90);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(90);
    test_random_traffic(90);

    recv_stall_pct = 20;
    test_backpressure();

    repeat (LATENCY + 8) @(posedge clk_i);
    if (servo_expect_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("** tilt_to_servo_pulse_unit: PASSED **");
    end else begin
      $display("** tilt_to_servo_pulse_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/tsp_pkg.sv
design/tsp_cordic_vec.sv
design/tilt_to_servo_pulse_unit.sv
tb/sv/tilt_to_servo_pulse_unit_tb.sv
